### rtl/core/aet_pkg.sv
// types, constants and helpers shared by the expression tokenizer
`default_nettype none

package aet_pkg;

  localparam int unsigned PosBits     = 16;
  localparam int unsigned FieldBits   = 16;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrBits = $clog2(FifoDepth);
  localparam int unsigned FifoCntBits = $clog2(FifoDepth + 1);

  localparam logic [PosBits-1:0]   PosMax  = {PosBits{1'b1}};
  localparam logic [FieldBits-1:0] LineMax = {FieldBits{1'b1}};
  localparam logic [FieldBits-1:0] LineOne = FieldBits'(1);

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChLparen  = 8'h28;
  localparam logic [7:0] ChRparen  = 8'h29;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChDigit0  = 8'd48;
  localparam logic [7:0] ChDigit9  = 8'd57;

  typedef enum logic [2:0] {
    ModeIdle,
    ModeInt,
    ModeFlt,
    ModeSlash,
    ModeComment
  } mode_e;

  typedef enum logic [3:0] {
    KindEnd,
    KindInt,
    KindFlt,
    KindPlus,
    KindMinus,
    KindStar,
    KindSlash,
    KindPercent,
    KindLparen,
    KindRparen,
    KindDot,
    KindError
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [FieldBits-1:0] offset;
    logic [FieldBits-1:0] length;
    logic [FieldBits-1:0] line;
    logic                 last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  function automatic logic [FieldBits-1:0] sat_pos(input logic [PosBits-1:0] v);
    logic [PosBits-1:0] lim;
    lim = PosBits'(LineMax);
    if (v > lim) begin
      return LineMax;
    end
    return FieldBits'(v);
  endfunction

endpackage

`default_nettype wire

### rtl/core/aet_lexer.sv
// lexer state and per-byte token decode
`default_nettype none

module aet_lexer (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic [7:0]     byte_i,
  output aet_pkg::push_t      push_o
);

  aet_pkg::mode_e                       mode_q, mode_d;
  logic [aet_pkg::PosBits-1:0]          pos_q, pos_d;
  logic [aet_pkg::PosBits-1:0]          begin_q, begin_d;
  logic [aet_pkg::FieldBits-1:0]        line_q, line_d;

  logic                                 is_digit;
  logic [aet_pkg::FieldBits-1:0]        line_inc;
  logic [aet_pkg::PosBits-1:0]          pos_inc;
  logic [aet_pkg::PosBits-1:0]          span;

  // open token handling
  logic                                 pre_emit;
  aet_pkg::kind_e                       pre_kind;
  logic [aet_pkg::FieldBits-1:0]        pre_len;
  logic                                 go_idle;
  aet_pkg::mode_e                       stay_mode;

  // fresh byte handling
  logic                                 idle_emit;
  logic                                 idle_end;
  logic                                 idle_nl;
  logic                                 idle_mark;
  aet_pkg::kind_e                       idle_kind;
  aet_pkg::mode_e                       idle_mode;
  logic                                 idle_out;

  aet_pkg::token_t                      tok_pre, tok_idle;

  assign is_digit = (byte_i >= aet_pkg::ChDigit0) && (byte_i <= aet_pkg::ChDigit9);
  assign line_inc = (line_q != aet_pkg::LineMax) ? line_q + aet_pkg::LineOne : line_q;
  assign pos_inc  = (pos_q != aet_pkg::PosMax) ? pos_q + aet_pkg::PosBits'(1) : pos_q;
  assign span     = (pos_q >= begin_q) ? pos_q - begin_q : '0;

  always_comb begin
    pre_emit  = 1'b0;
    pre_kind  = aet_pkg::KindInt;
    pre_len   = aet_pkg::sat_pos(span);
    go_idle   = 1'b0;
    stay_mode = mode_q;
    unique case (mode_q)
      aet_pkg::ModeInt: begin
        if (byte_i == aet_pkg::ChDot) begin
          stay_mode = aet_pkg::ModeFlt;
        end else if (!is_digit) begin
          pre_emit = 1'b1;
          go_idle  = 1'b1;
        end
      end
      aet_pkg::ModeFlt: begin
        if (!is_digit) begin
          pre_emit = 1'b1;
          pre_kind = aet_pkg::KindFlt;
          go_idle  = 1'b1;
        end
      end
      aet_pkg::ModeSlash: begin
        if (byte_i == aet_pkg::ChSlash) begin
          stay_mode = aet_pkg::ModeComment;
        end else begin
          pre_emit = 1'b1;
          pre_kind = aet_pkg::KindSlash;
          pre_len  = aet_pkg::FieldBits'(1);
          go_idle  = 1'b1;
        end
      end
      aet_pkg::ModeComment: begin
        // end byte and newline behave as they do between tokens
        if (byte_i == aet_pkg::ChNul || byte_i == aet_pkg::ChLf) begin
          go_idle = 1'b1;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase
  end

  always_comb begin
    idle_emit = 1'b0;
    idle_end  = 1'b0;
    idle_nl   = 1'b0;
    idle_mark = 1'b0;
    idle_kind = aet_pkg::KindError;
    idle_mode = aet_pkg::ModeIdle;
    unique case (byte_i)
      aet_pkg::ChNul:     idle_end = 1'b1;
      aet_pkg::ChSpace,
      aet_pkg::ChTab,
      aet_pkg::ChCr:      idle_emit = 1'b0;
      aet_pkg::ChLf:      idle_nl = 1'b1;
      aet_pkg::ChSlash: begin
        idle_mark = 1'b1;
        idle_mode = aet_pkg::ModeSlash;
      end
      aet_pkg::ChPlus: begin
        idle_emit = 1'b1;
        idle_kind = aet_pkg::KindPlus;
      end
      aet_pkg::ChMinus: begin
        idle_emit = 1'b1;
        idle_kind = aet_pkg::KindMinus;
      end
      aet_pkg::ChStar: begin
        idle_emit = 1'b1;
        idle_kind = aet_pkg::KindStar;
      end
      aet_pkg::ChPercent: begin
        idle_emit = 1'b1;
        idle_kind = aet_pkg::KindPercent;
      end
      aet_pkg::ChLparen: begin
        idle_emit = 1'b1;
        idle_kind = aet_pkg::KindLparen;
      end
      aet_pkg::ChRparen: begin
        idle_emit = 1'b1;
        idle_kind = aet_pkg::KindRparen;
      end
      aet_pkg::ChDot: begin
        idle_emit = 1'b1;
        idle_kind = aet_pkg::KindDot;
      end
      default: begin
        if (is_digit) begin
          idle_mark = 1'b1;
          idle_mode = aet_pkg::ModeInt;
        end else begin
          idle_emit = 1'b1;
        end
      end
    endcase
  end

  assign idle_out = go_idle && (idle_emit || idle_end);

  // next state
  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    begin_d = begin_q;
    line_d  = line_q;
    if (en_i) begin
      if (go_idle && idle_end) begin
        mode_d  = aet_pkg::ModeIdle;
        pos_d   = '0;
        begin_d = '0;
        line_d  = aet_pkg::LineOne;
      end else begin
        mode_d = go_idle ? idle_mode : stay_mode;
        pos_d  = pos_inc;
        if (go_idle && idle_mark) begin
          begin_d = pos_q;
        end
        if (go_idle && idle_nl) begin
          line_d = line_inc;
        end
      end
    end
  end

  // tokens for this byte
  always_comb begin
    tok_pre.kind    = pre_kind;
    tok_pre.offset  = aet_pkg::sat_pos(begin_q);
    tok_pre.length  = pre_len;
    tok_pre.line    = line_q;
    tok_pre.last    = !idle_out;

    tok_idle.kind   = idle_end ? aet_pkg::KindEnd : idle_kind;
    tok_idle.offset = aet_pkg::sat_pos(pos_q);
    tok_idle.length = idle_end ? '0 : aet_pkg::FieldBits'(1);
    tok_idle.line   = line_q;
    tok_idle.last   = 1'b1;

    push_o.first  = pre_emit ? tok_pre : tok_idle;
    push_o.second = tok_idle;
    push_o.count  = en_i ? (2'(pre_emit) + 2'(idle_out)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= aet_pkg::ModeIdle;
      pos_q   <= '0;
      begin_q <= '0;
      line_q  <= aet_pkg::LineOne;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      line_q  <= line_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/aet_out_fifo.sv
// small token queue taking up to two tokens a cycle
`default_nettype none

module aet_out_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire aet_pkg::push_t  push_i,
  input  wire logic            pop_i,
  output logic                 room_o,
  output logic                 valid_o,
  output aet_pkg::token_t      token_o
);

  aet_pkg::token_t                   mem_q [aet_pkg::FifoDepth];
  logic [aet_pkg::FifoPtrBits-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [aet_pkg::FifoCntBits-1:0]   cnt_q, cnt_d;
  logic [aet_pkg::FifoPtrBits-1:0]   wr_next;
  logic                              do_pop;

  assign valid_o = (cnt_q != '0);
  assign token_o = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;
  // room for two more words
  assign room_o  = (cnt_q <= aet_pkg::FifoCntBits'(aet_pkg::FifoDepth - 2));
  assign wr_next = wr_q + aet_pkg::FifoPtrBits'(1);

  always_comb begin
    wr_d  = wr_q + aet_pkg::FifoPtrBits'(push_i.count);
    rd_d  = rd_q + aet_pkg::FifoPtrBits'(do_pop);
    cnt_d = cnt_q + aet_pkg::FifoCntBits'(push_i.count) - aet_pkg::FifoCntBits'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/arithmetic_expression_tokenizer.sv
// top level of the arithmetic expression tokenizer
//
// Source bytes come in on the in_valid_i/in_ready_o channel, one byte per
// word; a zero byte marks the end of the buffer. Tokens leave on the
// out_valid_o/out_ready_i channel, one token per word, with last_of_run_o
// set on the final token that a byte produced.
// A byte is held in an input register, decoded once the queue has room
// for two words, and its zero, one or two tokens are written into a
// four-word token queue whose head drives the output.
// One byte is taken every cycle while the queue has room for two words;
// a byte giving two tokens adds two words, so with a ready receiver the
// sustained rate is one byte a cycle for bytes giving at most one token.
// When the receiver stalls, the queue holds over two words and in_ready_o
// drops once the input register holds a byte that cannot be decoded.
// Reset empties the queue and input register and puts the lexer between
// tokens at offset zero on line one; an end token resets only the lexer.
`default_nettype none

module arithmetic_expression_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  source_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       token_kind_o,
  output logic [15:0]      token_offset_o,
  output logic [15:0]      token_length_o,
  output logic [15:0]      token_line_o,
  output logic             last_of_run_o
);

  logic            byte_vld_q, byte_vld_d;
  logic [7:0]      byte_q;
  logic            room;
  logic            step_en;
  aet_pkg::push_t  push;
  aet_pkg::token_t head;

  assign step_en    = byte_vld_q && room;
  assign in_ready_o = !byte_vld_q || step_en;
  assign byte_vld_d = (in_valid_i && in_ready_o) || (byte_vld_q && !step_en);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= source_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else begin
      byte_vld_q <= byte_vld_d;
    end
  end

  aet_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_en),
    .byte_i (byte_q),
    .push_o (push)
  );

  aet_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_ready_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .token_o (head)
  );

  assign token_kind_o   = head.kind;
  assign token_offset_o = head.offset;
  assign token_length_o = head.length;
  assign token_line_o   = head.line;
  assign last_of_run_o  = head.last;

endmodule

`default_nettype wire

### rtl/core/aet_checker.sv
// port-level checks for the expression tokenizer
`default_nettype none

module aet_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [3:0]  token_kind_o,
  input wire logic [15:0] token_length_o,
  input wire logic [15:0] token_line_o,
  input wire logic        last_of_run_o
);

  // a stalled word holds its kind, length and line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o)
      && $stable(token_length_o) && $stable(token_line_o))
    else $error("stalled token changed");

  // end token has no length and closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == aet_pkg::KindEnd |->
      token_length_o == '0 && last_of_run_o)
    else $error("bad end token");

  // lines start at one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_line_o != '0)
    else $error("token on line zero");

  // operator and error tokens are one byte long
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != aet_pkg::KindEnd && token_kind_o != aet_pkg::KindInt
      && token_kind_o != aet_pkg::KindFlt |-> token_length_o == 16'd1)
    else $error("single byte token with wrong length");

  // nothing comes out in the cycle after reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("token right after reset");

endmodule

bind arithmetic_expression_tokenizer aet_checker u_aet_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .token_kind_o   (token_kind_o),
  .token_length_o (token_length_o),
  .token_line_o   (token_line_o),
  .last_of_run_o  (last_of_run_o)
);

`default_nettype wire

### verif/testbench.sv
// self-checking testbench for the arithmetic expression tokenizer
module testbench;
  import aet_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 150;
  localparam logic [7:0] OpChars [8] = '{ChPlus, ChMinus, ChStar, ChSlash, ChPercent,
                                         ChLparen, ChRparen, ChDot};
  localparam logic [7:0] BlankChars [4] = '{ChSpace, ChTab, ChCr, ChLf};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  source_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  token_kind_o;
  logic [15:0] token_offset_o;
  logic [15:0] token_length_o;
  logic [15:0] token_line_o;
  logic        last_of_run_o;

  arithmetic_expression_tokenizer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .source_byte_i (source_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .token_offset_o(token_offset_o),
    .token_length_o(token_length_o),
    .token_line_o  (token_line_o),
    .last_of_run_o (last_of_run_o)
  );

  always #4 clk_i = ~clk_i;

  logic [7:0]  source_stream [$];
  token_t      due_tokens [$];
  token_t      step_tokens [$];
  int unsigned send_idle = 15;
  int unsigned recv_idle = 47;
  int unsigned bytes_taken = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned faults = 0;
  int unsigned tokens_seen = 0;
  int unsigned cycles = 0;

  // lexer state mirrored for prediction
  mode_e              lex_mode = ModeIdle;
  logic [PosBits-1:0] lex_pos = '0;
  logic [PosBits-1:0] lex_start = '0;
  logic [15:0]        lex_line = 16'd1;
  logic               lex_ended = 1'b0;

  function automatic logic [15:0] clamp16(input logic [PosBits-1:0] v);
    longint unsigned u;
    u = 64'(v);
    return (u > 64'hFFFF) ? 16'hFFFF : u[15:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= ChDigit0 && b <= ChDigit9;
  endfunction

  function automatic void emit_token(input kind_e k, input logic [PosBits-1:0] off,
                                     input logic [PosBits-1:0] len);
    token_t t;
    t.kind   = k;
    t.offset = clamp16(off);
    t.length = clamp16(len);
    t.line   = lex_line;
    t.last   = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void bump_line();
    if (lex_line != 16'hFFFF) lex_line = lex_line + 16'd1;
  endfunction

  function automatic void close_buffer();
    emit_token(KindEnd, lex_pos, '0);
    lex_mode  = ModeIdle;
    lex_pos   = '0;
    lex_start = '0;
    lex_line  = 16'd1;
    lex_ended = 1'b1;
  endfunction

  function automatic logic [PosBits-1:0] number_span();
    return (lex_pos >= lex_start) ? lex_pos - lex_start : '0;
  endfunction

  function automatic void lex_fresh(input logic [7:0] b);
    kind_e k;
    lex_mode = ModeIdle;
    k = KindError;
    case (b)
      ChNul: begin
        close_buffer();
        return;
      end
      ChSpace, ChTab, ChCr: return;
      ChLf: begin
        bump_line();
        return;
      end
      ChSlash: begin
        lex_start = lex_pos;
        lex_mode  = ModeSlash;
        return;
      end
      ChPlus:    k = KindPlus;
      ChMinus:   k = KindMinus;
      ChStar:    k = KindStar;
      ChPercent: k = KindPercent;
      ChLparen:  k = KindLparen;
      ChRparen:  k = KindRparen;
      ChDot:     k = KindDot;
      default: begin
        if (is_digit(b)) begin
          lex_start = lex_pos;
          lex_mode  = ModeInt;
          return;
        end
      end
    endcase
    emit_token(k, lex_pos, PosBits'(1));
  endfunction

  function automatic void lex_byte(input logic [7:0] b);
    step_tokens.delete();
    lex_ended = 1'b0;
    case (lex_mode)
      ModeInt: begin
        if (b == ChDot) begin
          lex_mode = ModeFlt;
        end else if (!is_digit(b)) begin
          emit_token(KindInt, lex_start, number_span());
          lex_fresh(b);
        end
      end
      ModeFlt: begin
        if (!is_digit(b)) begin
          emit_token(KindFlt, lex_start, number_span());
          lex_fresh(b);
        end
      end
      ModeSlash: begin
        if (b == ChSlash) begin
          lex_mode = ModeComment;
        end else begin
          emit_token(KindSlash, lex_start, PosBits'(1));
          lex_fresh(b);
        end
      end
      ModeComment: begin
        if (b == ChNul) begin
          close_buffer();
        end else if (b == ChLf) begin
          bump_line();
          lex_mode = ModeIdle;
        end
      end
      default: lex_fresh(b);
    endcase
    if (!lex_ended && lex_pos != PosMax) lex_pos = lex_pos + PosBits'(1);
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) due_tokens.push_back(step_tokens[i]);
  endfunction

  task automatic report_fault(input string msg);
    $display("mismatch: %s", msg);
    faults++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        lex_byte(source_byte_i);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (source_stream.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          in_valid_i    <= 1'b1;
          source_byte_i <= source_stream.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HoldCycles;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_tokens.size() == 0) begin
          report_fault($sformatf("word %0d kind %0d offset %0d arrived with none due",
                                 tokens_seen, token_kind_o, token_offset_o));
        end else begin
          want = due_tokens.pop_front();
          if (token_kind_o !== 4'(want.kind))
            report_fault($sformatf("word %0d kind %0d, want %0d", tokens_seen,
                                   token_kind_o, want.kind));
          if (token_offset_o !== want.offset)
            report_fault($sformatf("word %0d offset %0d, want %0d", tokens_seen,
                                   token_offset_o, want.offset));
          if (token_length_o !== want.length)
            report_fault($sformatf("word %0d length %0d, want %0d", tokens_seen,
                                   token_length_o, want.length));
          if (token_line_o !== want.line)
            report_fault($sformatf("word %0d line %0d, want %0d", tokens_seen,
                                   token_line_o, want.line));
          if (last_of_run_o !== want.last)
            report_fault($sformatf("word %0d last %0b, want %0b", tokens_seen,
                                   last_of_run_o, want.last));
        end
        tokens_seen <= tokens_seen + 1;
      end
      if (hold_req != hold_seen || hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= $urandom_range(0, 99) >= recv_idle;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) source_stream.push_back(s[i]);
  endtask

  task automatic push_digits(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) source_stream.push_back(8'($urandom_range(48, 57)));
  endtask

  task automatic push_random(input int unsigned target);
    int unsigned added;
    int unsigned before_size;
    int unsigned r;
    added = 0;
    while (added < target) begin
      before_size = source_stream.size();
      r = $urandom_range(0, 99);
      if (r < 35) begin
        push_digits($urandom_range(1, 4));
        if ($urandom_range(0, 2) == 0) begin
          source_stream.push_back(ChDot);
          push_digits($urandom_range(0, 3));
        end
      end else if (r < 60) begin
        source_stream.push_back(OpChars[$urandom_range(0, 7)]);
      end else if (r < 70) begin
        source_stream.push_back(BlankChars[$urandom_range(0, 3)]);
      end else if (r < 74) begin
        source_stream.push_back(ChSlash);
        source_stream.push_back(ChSlash);
        repeat ($urandom_range(0, 5)) source_stream.push_back(8'($urandom_range(1, 255)));
        source_stream.push_back(ChLf);
      end else if (r < 84) begin
        source_stream.push_back(8'($urandom_range(1, 255)));
      end else if (r < 87) begin
        source_stream.push_back(ChNul);
      end else begin
        source_stream.push_back(ChSlash);
        push_digits($urandom_range(1, 2));
      end
      added += source_stream.size() - before_size;
    end
  endtask

  task automatic drain();
    while (source_stream.size() != 0 || in_valid_i) @(negedge clk_i);
    while (due_tokens.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed opening
    push_text("12.5+3../2 %(*)-");
    source_stream.push_back(8'hFF);
    source_stream.push_back(8'h80);
    source_stream.push_back(ChTab);
    source_stream.push_back(ChCr);
    push_text("\n//x\n9");
    source_stream.push_back(ChNul);
    source_stream.push_back(ChSlash);
    source_stream.push_back(ChNul);
    push_text("//");
    source_stream.push_back(ChNul);
    push_random(240);
    drain();

    // receiver busier than sender, with one long receiver hold-off
    send_idle = 47;
    recv_idle = 15;
    push_random(240);
    while (bytes_taken < 320) @(negedge clk_i);
    hold_req++;
    drain();

    // no idling
    send_idle = 0;
    recv_idle = 0;
    source_stream.push_back(ChNul);
    push_text("98765*/3.1+");
    repeat (4) source_stream.push_back(ChLf);
    push_text("7-");
    source_stream.push_back(ChNul);
    push_text("4.");
    source_stream.push_back(ChNul);
    drain();

    repeat (16) @(negedge clk_i);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
